[design/text_console_cursor_scroll_assert.svh]
// ----------------------------------------------------------------------------
// text console assertion macros
// shared concurrent assertion forms, sampled on clk_i, off while in reset
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define TCCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TCCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tccs_pkg.sv]
// ----------------------------------------------------------------------------
// text console package
// command codes, special characters and controller/datapath interface types
// ----------------------------------------------------------------------------
package tccs_pkg;

  // item commands
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // special character bytes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture the input item
    logic calc;     // work out cursor, address and write data
    logic access;   // screen store write or read
    logic sweep;    // write zero at the sweep address and step it
    logic advance;  // move the ring row origin down one row
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sweep_last;  // sweep address is at its final cell
    logic scroll;      // the current item scrolls the screen
  } dp_status_t;

endpackage

[design/tccs_ctrl.sv]
// ----------------------------------------------------------------------------
// text console controller
// sequences reset clearing, item execution, row scroll sweeps and the result
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_assert.svh"

module tccs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  tccs_pkg::dp_status_t status_i,
  output tccs_pkg::dp_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CALC   = 3'd2;
  localparam logic [2:0] ST_ACCESS = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_ACCESS;
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = status_i.scroll ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          cmd_o.advance = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  // checks
  `TCCS_ASSERT_NXT(a_accept_to_calc, (state_q == ST_IDLE) && start_i, state_q == ST_CALC,
                   "accepted item did not enter calc")
  `TCCS_ASSERT_NXT(a_done_single, done_o, !done_o && !busy_o,
                   "result strobe longer than one cycle")
  `TCCS_ASSERT_NXT(a_scroll_end, (state_q == ST_SCROLL) && status_i.sweep_last, done_o,
                   "scroll sweep end did not deliver the result")

endmodule

[design/tccs_datapath.sv]
// ----------------------------------------------------------------------------
// text console datapath
// item registers, cursor, ring row origin, sweep counter and screen store
// ----------------------------------------------------------------------------
module tccs_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tccs_pkg::dp_cmd_t    cmd_i,
  output tccs_pkg::dp_status_t status_o,
  input  logic                 cmd_in_i,
  input  logic [7:0]           ch_i,
  input  logic [7:0]           color_i,
  input  logic [4:0]           read_row_i,
  input  logic [6:0]           read_col_i,
  output logic [7:0]           cell_char_o,
  output logic [7:0]           cell_color_o,
  output logic [4:0]           cursor_row_o,
  output logic [6:0]           cursor_col_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_CELLS = AW'(COLUMNS);
  localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS - 1);
  localparam logic [RW:0]   ROWS_EXT  = (RW + 1)'(ROWS);

  // captured item
  logic          cmd_q;
  logic [7:0]    ch_q, color_q;
  logic [4:0]    rrow_q;
  logic [6:0]    rcol_q;

  // cursor and ring origin
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] origin_q;

  // pending access
  logic [AW-1:0] addr_q, addr_d;
  logic          we_q, we_d;
  logic [15:0]   wdata_q, wdata_d;
  logic          rd_ok_q, rd_ok_d;
  logic          scroll_q, scroll_d;
  logic [15:0]   rdata_q;

  // clearing sweep
  logic [AW-1:0] sweep_addr_q, sweep_end_q;
  logic [AW-1:0] scroll_base;

  // screen store
  logic [15:0]   mem_q [CELLS];

  logic [RW-1:0] lrow;
  logic [CW-1:0] lcol;
  logic [RW:0]   row_inc, psum, prow;
  logic [31:0]   rrow_ext, rcol_ext, cur_row_ext, cur_col_ext;
  logic          at_home;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;

  // capture item at transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= cmd_in_i;
      ch_q    <= ch_i;
      color_q <= color_i;
      rrow_q  <= read_row_i;
      rcol_q  <= read_col_i;
    end
  end

  assign rrow_ext = 32'(rrow_q);
  assign rcol_ext = 32'(rcol_q);
  assign row_inc  = {1'b0, cur_row_q} + (RW + 1)'(1);
  assign at_home  = (cur_row_q == '0) && (cur_col_q == '0);

  // cursor update and target cell
  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    lrow      = cur_row_q;
    lcol      = cur_col_q;
    we_d      = 1'b0;
    wdata_d   = '0;
    scroll_d  = 1'b0;
    rd_ok_d   = 1'b0;
    if (cmd_q == tccs_pkg::CMD_PUT) begin
      if (ch_q == tccs_pkg::CH_NEWLINE) begin
        cur_col_d = '0;
        if (cur_row_q == ROW_LAST) scroll_d = 1'b1;
        else cur_row_d = row_inc[RW-1:0];
      end else if (ch_q == tccs_pkg::CH_BACKSPACE) begin
        if (!at_home) begin
          we_d = 1'b1;
          if (cur_col_q == '0) begin
            cur_row_d = cur_row_q - RW'(1);
            cur_col_d = COL_LAST;
          end else begin
            cur_col_d = cur_col_q - CW'(1);
          end
          lrow = cur_row_d;
          lcol = cur_col_d;
        end
      end else begin
        we_d    = 1'b1;
        wdata_d = {color_q, ch_q};
        if (cur_col_q == COL_LAST) begin
          cur_col_d = '0;
          if (cur_row_q == ROW_LAST) scroll_d = 1'b1;
          else cur_row_d = row_inc[RW-1:0];
        end else begin
          cur_col_d = cur_col_q + CW'(1);
        end
      end
    end else begin
      rd_ok_d = (rrow_ext < ROWS) && (rcol_ext < COLUMNS);
      lrow    = rrow_ext[RW-1:0];
      lcol    = rcol_ext[CW-1:0];
    end
  end

  // logical row to physical row through the ring origin
  assign psum        = {1'b0, lrow} + {1'b0, origin_q};
  assign prow        = (psum >= ROWS_EXT) ? (psum - ROWS_EXT) : psum;
  assign addr_d      = AW'(prow[RW-1:0]) * ROW_CELLS + AW'(lcol);
  assign scroll_base = AW'(origin_q) * ROW_CELLS;

  // control state: cursor, origin, flags and sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      origin_q     <= '0;
      we_q         <= 1'b0;
      rd_ok_q      <= 1'b0;
      scroll_q     <= 1'b0;
      sweep_addr_q <= '0;
      sweep_end_q  <= CELL_LAST;
    end else begin
      if (cmd_i.calc) begin
        cur_row_q <= cur_row_d;
        cur_col_q <= cur_col_d;
        we_q      <= we_d;
        rd_ok_q   <= rd_ok_d;
        scroll_q  <= scroll_d;
        if (scroll_d) begin
          sweep_addr_q <= scroll_base;
          sweep_end_q  <= scroll_base + ROW_SPAN;
        end
      end else if (cmd_i.sweep) begin
        sweep_addr_q <= sweep_addr_q + AW'(1);
      end
      if (cmd_i.advance) begin
        origin_q <= (origin_q == ROW_LAST) ? '0 : origin_q + RW'(1);
      end
    end
  end

  // access payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      addr_q  <= addr_d;
      wdata_q <= wdata_d;
    end
  end

  // one write port: item access or zero sweep
  assign mem_we = (cmd_i.access && we_q) || cmd_i.sweep;
  assign mem_wa = cmd_i.sweep ? sweep_addr_q : addr_q;
  assign mem_wd = cmd_i.sweep ? 16'h0000 : wdata_q;

  // screen store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.access) rdata_q <= mem_q[addr_q];
  end

  assign status_o.sweep_last = (sweep_addr_q == sweep_end_q);
  assign status_o.scroll     = scroll_q;

  // result fields
  assign cell_char_o  = rd_ok_q ? rdata_q[7:0]  : 8'h00;
  assign cell_color_o = rd_ok_q ? rdata_q[15:8] : 8'h00;
  assign cur_row_ext  = 32'(cur_row_q);
  assign cur_col_ext  = 32'(cur_col_q);
  assign cursor_row_o = cur_row_ext[4:0];
  assign cursor_col_o = cur_col_ext[6:0];

endmodule

[design/text_console_cursor_scroll.sv]
// ----------------------------------------------------------------------------
// text console cursor and scroll engine
// screen store of character/colour cells with a cursor, newline, backspace,
// line wrap and one-line scroll through a ring row origin
//
//   channel  handshake               payload
//   item     start, busy             cmd_i ch_i color_i read_row_i read_col_i
//                                    string_end_i
//   result   done_o (one cycle)      cell_char_o cell_color_o cursor_row_o
//                                    cursor_col_o
//
// done_o rises once the item has passed through the calc and access states (and
// the scroll sweep, when there is one); busy stays high through the done_o cycle,
// so a new item is taken only after the last one has delivered its result
// a put that scrolls also clears the new row through the single write port
// after reset the store is cleared one cell a cycle, all ROWS*COLUMNS cells,
// with busy high; items are transferred only while busy is low
// the result is flagged valid by done_o alone; nothing stalls it
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cmd_i,
  input  logic [7:0] ch_i,
  input  logic [7:0] color_i,
  input  logic [4:0] read_row_i,
  input  logic [6:0] read_col_i,
  input  logic       string_end_i,
  output logic       done_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_color_o,
  output logic [4:0] cursor_row_o,
  output logic [6:0] cursor_col_o
);

  tccs_pkg::dp_cmd_t    dp_cmd;
  tccs_pkg::dp_status_t dp_status;

  // sequencing
  tccs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (dp_status),
    .cmd_o    (dp_cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // screen, cursor and sweep
  tccs_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .cmd_in_i     (cmd_i),
    .ch_i         (ch_i),
    .color_i      (color_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .cell_char_o  (cell_char_o),
    .cell_color_o (cell_color_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o)
  );

  // string_end_i only marks call boundaries and does not change the console
  logic unused_string_end;
  assign unused_string_end = string_end_i;

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// text console cursor and scroll engine testbench
// directed table then random put/read traffic; every result is compared
// field by field against a typed row's own view or a shadow screen and cursor in the testbench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int RANDOM_ITEMS = 1525;
  localparam int N_DIRECTED   = 25;
  // covers the clearing pass after reset, the longest sender gap and a scroll
  localparam int IDLE_LIMIT   = 4 * ROWS * COLUMNS + 1000;

  // short local names for the package codes
  localparam logic       OP_PUT  = tccs_pkg::CMD_PUT;
  localparam logic       OP_READ = tccs_pkg::CMD_READ;
  localparam logic [7:0] CH_NL   = tccs_pkg::CH_NEWLINE;
  localparam logic [7:0] CH_BS   = tccs_pkg::CH_BACKSPACE;

  // what one result shows: cell bytes and cursor
  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
  } console_view_t;

  // one row of the directed table; typed rows carry their own expected view
  typedef struct {
    logic          cmd;
    logic [7:0]    ch;
    logic [7:0]    color;
    logic [4:0]    rd_row;
    logic [6:0]    rd_col;
    logic          str_end;
    int            reps;
    bit            typed;
    console_view_t view;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       cmd_i;
  logic [7:0] ch_i;
  logic [7:0] color_i;
  logic [4:0] read_row_i;
  logic [6:0] read_col_i;
  logic       string_end_i;
  logic       done_o;
  logic [7:0] cell_char_o;
  logic [7:0] cell_color_o;
  logic [4:0] cursor_row_o;
  logic [6:0] cursor_col_o;

  // shadow of the screen store and cursor
  logic [15:0]   shadow_screen [ROWS][COLUMNS];
  int            cur_row;
  int            cur_col;
  console_view_t console_view_q [$];
  stim_row_t     directed_rows [N_DIRECTED];
  int            mismatch_count;
  int            idle_cycles;
  int            burst_left;

  text_console_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .ch_i        (ch_i),
    .color_i     (color_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .string_end_i(string_end_i),
    .done_o      (done_o),
    .cell_char_o (cell_char_o),
    .cell_color_o(cell_color_o),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // move every row up one and blank the bottom row
  function automatic void shadow_scroll();
    for (int r = 0; r < ROWS - 1; r++) begin
      for (int c = 0; c < COLUMNS; c++) shadow_screen[r][c] = shadow_screen[r + 1][c];
    end
    for (int c = 0; c < COLUMNS; c++) shadow_screen[ROWS - 1][c] = '0;
  endfunction

  // apply one item to the shadow and return the view it produces
  function automatic console_view_t console_apply(logic cmd, logic [7:0] ch,
                                                  logic [7:0] color, logic [4:0] rd_row,
                                                  logic [6:0] rd_col);
    console_view_t v;
    v = '0;
    if (cmd == OP_PUT) begin
      if (ch == CH_NL) begin
        cur_col = 0;
        cur_row++;
      end else if (ch == CH_BS) begin
        // nothing to erase at the top-left cell
        if (cur_row != 0 || cur_col != 0) begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = COLUMNS;
          end
          cur_col--;
          shadow_screen[cur_row][cur_col] = '0;
        end
      end else begin
        shadow_screen[cur_row][cur_col] = {color, ch};
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      if (cur_row >= ROWS) begin
        shadow_scroll();
        cur_row = ROWS - 1;
      end
    end else if (rd_row < ROWS && rd_col < COLUMNS) begin
      v.cell_char  = shadow_screen[rd_row][rd_col][7:0];
      v.cell_color = shadow_screen[rd_row][rd_col][15:8];
    end
    v.cursor_row = 5'(cur_row);
    v.cursor_col = 7'(cur_col);
    return v;
  endfunction

  // drive one item, wait for its transfer, then maybe leave a gap
  task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [7:0] color,
                           input logic [4:0] rd_row, input logic [6:0] rd_col,
                           input logic str_end, input bit typed,
                           input console_view_t typed_view);
    console_view_t v;
    int gap;
    start        <= 1'b1;
    cmd_i        <= cmd;
    ch_i         <= ch;
    color_i      <= color;
    read_row_i   <= rd_row;
    read_col_i   <= rd_col;
    string_end_i <= str_end;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    v = console_apply(cmd, ch, color, rd_row, rd_col);
    console_view_q.push_back(typed ? typed_view : v);
    // bursts of random length, some long, with random gaps between them
    if (burst_left == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 20);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  // compare one field of a result
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    console_view_t want;
    if (rst_ni && done_o) begin
      if (console_view_q.size() == 0) begin
        $error("result with no transfer pending: char %0d color %0d row %0d col %0d",
               cell_char_o, cell_color_o, cursor_row_o, cursor_col_o);
        mismatch_count++;
      end else begin
        want = console_view_q.pop_front();
        check_field("cell_char", want.cell_char, cell_char_o);
        check_field("cell_color", want.cell_color, cell_color_o);
        check_field("cursor_row", want.cursor_row, cursor_row_o);
        check_field("cursor_col", want.cursor_col, cursor_col_o);
      end
    end
  end

  // watchdog on cycles with no transfer and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic       cmd;
    logic [7:0] ch;
    logic [7:0] color;
    logic [4:0] rd_row;
    logic [6:0] rd_col;
    logic       str_end;
    int         pick;

    rst_ni         <= 1'b0;
    start          <= 1'b0;
    cmd_i          <= OP_PUT;
    ch_i           <= '0;
    color_i        <= '0;
    read_row_i     <= '0;
    read_col_i     <= '0;
    string_end_i   <= 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    cur_row        = 0;
    cur_col        = 0;
    burst_left     = $urandom_range(1, 20);
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLUMNS; c++) shadow_screen[r][c] = '0;
    end

    // directed table: reset contents, ignored backspace, wraps, extremes,
    // reads out of range, then a run down to the last row and two scrolls
    directed_rows = '{
      '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd0,   1'b0, 1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
      '{OP_READ, 8'h00, 8'h00, 5'd31, 7'd127, 1'b1, 1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
      '{OP_PUT,  CH_BS, 8'h07, 5'd0,  7'd0,   1'b1, 1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
      '{OP_PUT,  8'h41, 8'h1e, 5'd0,  7'd0,   1'b0, 1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
      '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd0,   1'b0, 1,  1'b1, '{8'h41, 8'h1e, 5'd0, 7'd1}},
      '{OP_PUT,  CH_NL, 8'h00, 5'd0,  7'd0,   1'b1, 1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
      '{OP_PUT,  CH_BS, 8'h00, 5'd0,  7'd0,   1'b0, 1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd79}},
      '{OP_PUT,  8'hff, 8'hff, 5'd31, 7'd127, 1'b1, 1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
      '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd79,  1'b0, 1,  1'b1, '{8'hff, 8'hff, 5'd1, 7'd0}},
      '{OP_PUT,  8'h00, 8'h00, 5'd0,  7'd0,   1'b0, 1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd1}},
      '{OP_PUT,  CH_BS, 8'h00, 5'd0,  7'd0,   1'b0, 1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
      '{OP_READ, 8'h00, 8'h00, 5'd1,  7'd0,   1'b0, 1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
      '{OP_READ, 8'h00, 8'h00, 5'd24, 7'd79,  1'b0, 1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
      '{OP_READ, 8'h00, 8'h00, 5'd25, 7'd0,   1'b0, 1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
      '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd80,  1'b0, 1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
      '{OP_PUT,  8'h7f, 8'h80, 5'd0,  7'd0,   1'b1, 1,  1'b0, '0},
      '{OP_PUT,  CH_NL, 8'h00, 5'd0,  7'd0,   1'b0, 23, 1'b0, '0},
      '{OP_PUT,  8'h78, 8'h55, 5'd0,  7'd0,   1'b0, 1,  1'b0, '0},
      '{OP_PUT,  CH_NL, 8'h00, 5'd0,  7'd0,   1'b1, 1,  1'b0, '0},
      '{OP_READ, 8'h00, 8'h00, 5'd23, 7'd0,   1'b0, 1,  1'b0, '0},
      '{OP_READ, 8'h00, 8'h00, 5'd24, 7'd0,   1'b0, 1,  1'b0, '0},
      '{OP_PUT,  8'h5a, 8'haa, 5'd0,  7'd0,   1'b0, 80, 1'b0, '0},
      '{OP_READ, 8'h00, 8'h00, 5'd23, 7'd79,  1'b0, 1,  1'b0, '0},
      '{OP_PUT,  CH_BS, 8'h00, 5'd0,  7'd0,   1'b0, 1,  1'b0, '0},
      '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd0,   1'b0, 1,  1'b0, '0}
    };

    // reset
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_item(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].color,
                  directed_rows[i].rd_row, directed_rows[i].rd_col,
                  directed_rows[i].str_end, directed_rows[i].typed, directed_rows[i].view);
      end
    end

    // random text: mostly printed bytes with newlines, backspaces and reads
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick    = $urandom_range(0, 99);
      cmd     = OP_PUT;
      ch      = 8'($urandom_range(0, 255));
      color   = 8'($urandom_range(0, 255));
      rd_row  = 5'($urandom_range(0, ROWS - 1));
      rd_col  = 7'($urandom_range(0, COLUMNS - 1));
      str_end = ($urandom_range(0, 7) == 0);
      if (pick < 12) begin
        ch = CH_NL;
      end else if (pick < 22) begin
        ch = CH_BS;
      end else if (pick < 37) begin
        // read around the cursor, where the text just went
        cmd    = OP_READ;
        rd_row = 5'(cur_row);
        rd_col = 7'($urandom_range((cur_col > 3) ? cur_col - 4 : 0,
                                   (cur_col < COLUMNS - 1) ? cur_col + 1 : cur_col));
      end else if (pick < 44) begin
        cmd = OP_READ;
      end else if (pick < 47) begin
        // any address, in range or not
        cmd    = OP_READ;
        rd_row = 5'($urandom_range(0, 31));
        rd_col = 7'($urandom_range(0, 127));
      end
      send_item(cmd, ch, color, rd_row, rd_col, str_end, 1'b0, '0);
    end
    start <= 1'b0;

    // drain, then allow for a scroll still in flight
    while (console_view_q.size() != 0) @(posedge clk_i);
    repeat (COLUMNS + 20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[text_console_cursor_scroll.f]
+incdir+design
design/tccs_pkg.sv
design/tccs_ctrl.sv
design/tccs_datapath.sv
design/text_console_cursor_scroll.sv
sim/tb_top.sv
